### design/rsa_pkg.sv
// rsa_pkg: shared types and constants of the reference-counted slot allocator
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps

package rsa_pkg;

	localparam int SLOTS_DEF       = 256;
	localparam int COUNT_LIMIT_DEF = 1024;

	localparam int HANDLE_W = 8;
	localparam int COUNT_W  = 11;

	localparam logic [1:0] CMD_CREATE = 2'd0;
	localparam logic [1:0] CMD_INC    = 2'd1;
	localparam logic [1:0] CMD_DEC    = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	typedef struct packed {
		logic [1:0]          cmd;
		logic [HANDLE_W-1:0] handle;
	} req_item_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] slot;
		logic [1:0]          status;
		logic                released;
		logic [COUNT_W-1:0]  ref_count;
	} rsp_item_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic commit;
	} rsa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} rsa_sts_t;

endpackage

### design/rsa_ctrl.sv
// rsa_ctrl: two-state sequencer, latch an item then commit its update
// depends on rsa_pkg
`timescale 1ns / 1ps

module rsa_ctrl import rsa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  rsa_sts_t sts,
	output rsa_cmd_t cmd
);

	localparam logic [0:0] S_IDLE = 1'b0;
	localparam logic [0:0] S_EXEC = 1'b1;

	logic [0:0] state_q;
	logic [0:0] state_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				// hold until the result register can take the new item
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### design/rsa_datapath.sv
// rsa_datapath: occupancy bitmap, free-slot tree, count memory and result register
// depends on rsa_pkg; driven by rsa_ctrl
`timescale 1ns / 1ps

module rsa_datapath import rsa_pkg::*; #(
	parameter int SLOTS       = SLOTS_DEF,
	parameter int COUNT_LIMIT = COUNT_LIMIT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_item_t req,
	input  rsa_cmd_t  cmd,
	output rsa_sts_t  sts,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	localparam int AW  = $clog2(SLOTS);
	localparam int CW  = $clog2(COUNT_LIMIT + 1);
	localparam int XW  = (AW > HANDLE_W) ? AW : HANDLE_W;
	localparam int RW  = (CW > COUNT_W) ? CW : COUNT_W;
	localparam int GW  = 16;
	localparam int LW  = $clog2(GW);
	localparam int G   = (SLOTS + GW - 1) / GW;
	localparam int GAW = (G > 1) ? $clog2(G) : 1;
	localparam int PW  = G * GW;

	localparam logic [CW-1:0] LIMIT = CW'(COUNT_LIMIT);
	localparam logic [CW-1:0] ONE   = CW'(1);

	// lowest clear bit of a group word
	function automatic logic [LW-1:0] low_zero(input logic [GW-1:0] w);
		logic [LW-1:0] idx;
		idx = '0;
		for (int i = GW - 1; i >= 0; i--) begin
			if (!w[i]) idx = LW'(i);
		end
		return idx;
	endfunction

	// latched item
	logic [1:0]          cmd_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [AW-1:0]       haddr_q;

	logic [XW-1:0] req_hx;
	logic [AW-1:0] req_haddr;

	// occupancy and group summaries
	logic [SLOTS-1:0] occ_q;
	logic [SLOTS-1:0] occ_d;
	logic [PW-1:0]    occ_pad_d;
	logic [G-1:0]     grp_free_q;
	logic [LW-1:0]    grp_low_q [G];

	// count memory
	logic [CW-1:0] cnt_mem [SLOTS];
	logic [CW-1:0] rd_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [CW-1:0] mem_wd;

	// result register
	logic      out_valid_q;
	rsp_item_t rsp_q;
	rsp_item_t res;

	// execute stage signals
	logic [GAW-1:0]    gsel;
	logic              any_free;
	logic [GAW+LW-1:0] free_wide;
	logic [AW-1:0]     free_idx;
	logic [XW-1:0]     free_x;
	logic              h_ok;
	logic [CW-1:0]     c_new;
	logic [RW-1:0]     cnt_x;
	logic              set_bit;
	logic              clr_bit;

	assign req_hx    = XW'(req.handle);
	assign req_haddr = req_hx[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q    <= req.cmd;
			handle_q <= req.handle;
			haddr_q  <= req_haddr;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) cnt_mem[mem_wa] <= mem_wd;
		if (cmd.accept) rd_q <= cnt_mem[req_haddr];
	end

	// lowest free group, then its stored lowest free bit
	always_comb begin
		gsel = '0;
		for (int g = G - 1; g >= 0; g--) begin
			if (grp_free_q[g]) gsel = GAW'(g);
		end
	end

	assign any_free  = |grp_free_q;
	assign free_wide = {gsel, grp_low_q[gsel]};
	assign free_idx  = free_wide[AW-1:0];
	assign free_x    = XW'(free_idx);
	assign h_ok      = (int'(handle_q) < SLOTS) && occ_q[haddr_q];

	always_comb begin
		res           = '0;
		res.slot      = handle_q;
		res.status    = ST_INVALID;
		mem_we        = 1'b0;
		mem_wa        = haddr_q;
		mem_wd        = '0;
		set_bit       = 1'b0;
		clr_bit       = 1'b0;
		c_new         = rd_q;
		cnt_x         = '0;
		case (cmd_q)
			CMD_CREATE: begin
				if (any_free) begin
					res.slot      = free_x[HANDLE_W-1:0];
					res.status    = ST_OK;
					res.ref_count = COUNT_W'(1);
					mem_we        = 1'b1;
					mem_wa        = free_idx;
					mem_wd        = ONE;
					set_bit       = 1'b1;
				end else begin
					res.slot   = '0;
					res.status = ST_FULL;
				end
			end
			CMD_INC: begin
				if (h_ok) begin
					if (rd_q != '0 && rd_q < LIMIT) begin
						c_new      = rd_q + ONE;
						mem_we     = 1'b1;
						mem_wd     = c_new;
						res.status = ST_OK;
					end
					cnt_x         = RW'(c_new);
					res.ref_count = cnt_x[COUNT_W-1:0];
				end
			end
			CMD_DEC: begin
				if (h_ok && rd_q != '0) begin
					// a count at the limit sticks there
					if (rd_q < LIMIT) c_new = rd_q - ONE;
					mem_we        = 1'b1;
					mem_wd        = c_new;
					res.status    = ST_OK;
					res.released  = (c_new == '0);
					clr_bit       = (c_new == '0);
					cnt_x         = RW'(c_new);
					res.ref_count = cnt_x[COUNT_W-1:0];
				end
			end
			default: begin
				res.status = ST_INVALID;
			end
		endcase
		if (!cmd.commit) begin
			mem_we  = 1'b0;
			set_bit = 1'b0;
			clr_bit = 1'b0;
		end
	end

	always_comb begin
		occ_d = occ_q;
		if (set_bit) occ_d[free_idx] = 1'b1;
		if (clr_bit) occ_d[haddr_q] = 1'b0;
	end

	// padding bits past the table read as occupied
	always_comb begin
		for (int i = 0; i < PW; i++) begin
			if (i < SLOTS) occ_pad_d[i] = occ_d[i];
			else occ_pad_d[i] = 1'b1;
		end
	end

	// summaries are built from the next bitmap so they are never stale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q      <= '0;
			grp_free_q <= '1;
		end else begin
			occ_q <= occ_d;
			for (int g = 0; g < G; g++) begin
				grp_free_q[g] <= ~(&occ_pad_d[g*GW +: GW]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < G; g++) grp_low_q[g] <= '0;
		end else begin
			for (int g = 0; g < G; g++) grp_low_q[g] <= low_zero(occ_pad_d[g*GW +: GW]);
		end
	end

	assign sts.out_free = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) rsp_q <= res;
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed item not presented");
	a_release_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && res.released) |=> !occ_q[$past(haddr_q)])
		else $error("released slot still occupied");
	a_create_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && cmd_q == CMD_CREATE && any_free) |=> occ_q[$past(free_idx)])
		else $error("created slot not marked occupied");
	a_one_change: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(occ_q ^ $past(occ_q)) <= 1)
		else $error("more than one occupancy bit changed");
`endif

endmodule

### design/refcounted_slot_allocator.sv
// refcounted_slot_allocator: top level, sequencer plus datapath
// depends on rsa_pkg, rsa_ctrl, rsa_datapath
`timescale 1ns / 1ps

// Handle table with an occupancy bitmap and a reference count per slot. Each
// item is handled in an accept step, which latches the command and reads the
// slot's count from the count memory, then an execute step, which updates bitmap
// and count and loads the result register; no new item is taken until it ends.
// The execute step is held while the previous result still waits on rsp_stall.
// The lowest free slot comes from per-group summaries of 16 slots, kept in
// registers built from the next bitmap value. The bitmap resets to all free
// at once; there is no clearing pass and counts need no reset.
module refcounted_slot_allocator import rsa_pkg::*; #(
	parameter int SLOTS       = SLOTS_DEF,
	parameter int COUNT_LIMIT = COUNT_LIMIT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	rsa_cmd_t cmd;
	rsa_sts_t sts;

	rsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rsa_datapath #(
		.SLOTS       (SLOTS),
		.COUNT_LIMIT (COUNT_LIMIT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

### tb/tb_refcounted_slot_allocator.sv
// tb_refcounted_slot_allocator: self-checking bench for the reference-counted slot allocator
// depends on rsa_pkg and refcounted_slot_allocator; a scoreboard class keeps a shadow table
// directed corner items, then random traffic around a full-table fill
`timescale 1ns / 1ps

module tb_refcounted_slot_allocator import rsa_pkg::*; ();

	localparam int SLOTS       = SLOTS_DEF;
	localparam int COUNT_LIMIT = COUNT_LIMIT_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// shadow of the handle table: occupancy, counts and the results still owed
	class alloc_scoreboard;
		bit        taken [SLOTS];
		int        refs [SLOTS];
		rsp_item_t rsp_due [$];
		int        errors;

		function void note_cmd(req_item_t it);
			rsp_item_t r;
			int h;
			int lowest;
			h = it.handle;
			lowest = -1;
			r = '0;
			r.slot = it.handle;
			r.status = ST_INVALID;
			if (it.cmd == CMD_CREATE) begin
				for (int i = SLOTS - 1; i >= 0; i--)
					if (!taken[i])
						lowest = i;
				if (lowest < 0) begin
					r.slot = '0;
					r.status = ST_FULL;
				end else begin
					taken[lowest] = 1'b1;
					refs[lowest] = 1;
					r.slot = HANDLE_W'(lowest);
					r.status = ST_OK;
					r.ref_count = COUNT_W'(1);
				end
			end else if (it.cmd == CMD_UNUSED || h >= SLOTS || !taken[h]) begin
				// free slot or unused command: defaults stand
			end else if (it.cmd == CMD_INC) begin
				if (refs[h] > 0 && refs[h] < COUNT_LIMIT) begin
					refs[h]++;
					r.status = ST_OK;
				end
				r.ref_count = COUNT_W'(refs[h]);
			end else if (refs[h] > 0) begin
				// count at the limit is sticky
				if (refs[h] < COUNT_LIMIT)
					refs[h]--;
				r.status = ST_OK;
				r.ref_count = COUNT_W'(refs[h]);
				if (refs[h] == 0) begin
					taken[h] = 1'b0;
					r.released = 1'b1;
				end
			end
			rsp_due.push_back(r);
		endfunction

		function void cmp_field(string name, int want, int got);
			if (want != got) begin
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_rsp(rsp_item_t got);
			rsp_item_t want;
			if (rsp_due.size() == 0) begin
				$display("%0t: unexpected item: expected none, got slot %0d status %0d count %0d",
					$time, got.slot, got.status, got.ref_count);
				errors++;
				return;
			end
			want = rsp_due.pop_front();
			cmp_field("slot", want.slot, got.slot);
			cmp_field("status", want.status, got.status);
			cmp_field("released", want.released, got.released);
			cmp_field("ref_count", want.ref_count, got.ref_count);
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp;

	alloc_scoreboard sb = new;
	bit idle_on = 1'b0;
	int rsp_hold = 0;
	int cycles = 0;

	refcounted_slot_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver stalls in bursts of random length while idle_on is set
	always @(posedge clk) begin
		if (rsp_hold > 0) begin
			rsp_hold <= rsp_hold - 1;
			rsp_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			rsp_hold <= $urandom_range(0, 10);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// inputs only move at rising edges, so the negedge view is what the next edge takes
	always @(negedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_rsp(rsp);
	end

	task automatic send(input logic [1:0] cmd, input logic [7:0] handle);
		req_item_t it;
		it.cmd = cmd;
		it.handle = handle;
		if (idle_on && $urandom_range(0, 2) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		@(negedge clk);
		while (req_stall)
			@(negedge clk);
		@(posedge clk);
		sb.note_cmd(it);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.rsp_due.size() != 0);
	endtask

	function automatic logic [7:0] live_handle();
		int live [$];
		for (int i = 0; i < SLOTS; i++)
			if (sb.taken[i])
				live.push_back(i);
		if (live.size() == 0)
			return 8'($urandom);
		return 8'(live[$urandom_range(0, live.size() - 1)]);
	endfunction

	task automatic random_item(input int create_pct);
		int roll;
		logic [1:0] cmd;
		roll = $urandom_range(0, 99);
		if (roll < create_pct) begin
			send(CMD_CREATE, 8'($urandom));
		end else if (roll < 95) begin
			cmd = ($urandom_range(0, 1) == 0) ? CMD_INC : CMD_DEC;
			// mostly live handles, now and then any handle
			if ($urandom_range(0, 9) == 0)
				send(cmd, 8'($urandom));
			else
				send(cmd, live_handle());
		end else begin
			send(CMD_UNUSED, 8'($urandom));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;

		send(CMD_INC, 8'h00);
		send(CMD_DEC, 8'hFF);
		send(CMD_UNUSED, 8'hA5);
		send(CMD_CREATE, 8'hFF);
		send(CMD_CREATE, 8'h00);
		send(CMD_INC, 8'h00);
		send(CMD_INC, 8'h00);
		send(CMD_DEC, 8'h00);
		send(CMD_DEC, 8'h01);
		send(CMD_CREATE, 8'h5A);
		send(CMD_UNUSED, 8'h00);
		send(CMD_DEC, 8'h00);
		send(CMD_DEC, 8'h00);
		send(CMD_DEC, 8'h00);
		send(CMD_INC, 8'hFF);
		send(CMD_UNUSED, 8'h5A);
		send(CMD_DEC, 8'h01);
		drain();

		for (int n = 0; n < 300; n++) begin
			if (n % 75 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			random_item(35);
		end
		drain();

		// fill the table and keep asking once it is full
		idle_on = 1'b1;
		repeat (SLOTS + 3)
			send(CMD_CREATE, 8'($urandom));

		for (int n = 0; n < 300; n++) begin
			if (n % 75 == 0)
				idle_on = (n < 225) && ($urandom_range(0, 3) != 0);
			random_item(20);
		end
		idle_on = 1'b0;
		drain();
		repeat (8) @(posedge clk);

		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
